### rtl/two_sat_scc_checker_unit_macros.svh
// Assertion macros for the two-SAT component checker.
// Used by the top level only; expands to nothing under synthesis.
`ifndef TWO_SAT_SCC_CHECKER_UNIT_MACROS_SVH
`define TWO_SAT_SCC_CHECKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TSAT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TSAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TSAT_ASSERT(lbl, cond, msg)
`define TSAT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### rtl/tsat_pkg.sv
// Shared types, sizes and helpers for the two-SAT component checker.
// No dependencies.
`timescale 1ns / 1ps
package tsat_pkg;
	localparam int MAX_VARS        = 256;
	localparam int MAX_CONSTRAINTS = 1024;
	localparam int MAX_EDGES       = 4 * MAX_CONSTRAINTS;

	typedef struct packed {
		logic [9:0] lit_a;
		logic [9:0] lit_b;
		logic       last;
	} req_t;

	typedef struct packed {
		logic       satisfiable;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [12:0] head;
		logic [9:0]  visit;
		logic [9:0]  low;
		logic [9:0]  comp;
	} node_word_t;

	typedef struct packed {
		logic [9:0]  target;
		logic [12:0] link;
	} edge_word_t;

	typedef struct packed {
		logic [9:0]  node;
		logic [12:0] eptr;
	} frame_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// Nodes are numbered from one; memories are indexed from zero.
	function automatic logic [8:0] node_addr(input logic [9:0] node);
		logic [9:0] t;
		t = node - 10'd1;
		return t[8:0];
	endfunction

	function automatic logic [11:0] edge_addr(input logic [12:0] eptr);
		logic [12:0] t;
		t = eptr - 13'd1;
		return t[11:0];
	endfunction

	function automatic logic [9:0] negate(input logic [9:0] lit, input logic [8:0] n);
		logic [9:0] nn;
		nn = {1'b0, n};
		return (lit > nn) ? lit - nn : lit + nn;
	endfunction
endpackage

### rtl/two_sat_scc_checker_unit.sv
// Two-SAT checker: loads constraints, then runs an iterative Tarjan search.
// Loading writes four implication edges per word, each by a read and a write of a node list head.
// No word is accepted until all four are stored; solving is bounded by the node memory port.
// After each result, and after reset, a sweep clears all 512 node memory words;
// no word is accepted during it.
// Depends on tsat_pkg, tsat_ram and two_sat_scc_checker_unit_macros.svh.
`timescale 1ns / 1ps
`include "two_sat_scc_checker_unit_macros.svh"
module two_sat_scc_checker_unit
	import tsat_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);
	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_ADD_RD = 5'd2;
	localparam logic [4:0] S_ADD_WR = 5'd3;
	localparam logic [4:0] S_INIT   = 5'd4;
	localparam logic [4:0] S_R_RD   = 5'd5;
	localparam logic [4:0] S_R_CHK  = 5'd6;
	localparam logic [4:0] S_W_TOP  = 5'd7;
	localparam logic [4:0] S_W_EDGE = 5'd8;
	localparam logic [4:0] S_W_V    = 5'd9;
	localparam logic [4:0] S_P_A    = 5'd10;
	localparam logic [4:0] S_P_B    = 5'd11;
	localparam logic [4:0] S_P_C    = 5'd12;
	localparam logic [4:0] S_F_A    = 5'd13;
	localparam logic [4:0] S_F_B    = 5'd14;
	localparam logic [4:0] S_F_C    = 5'd15;
	localparam logic [4:0] S_C_A    = 5'd16;
	localparam logic [4:0] S_C_B    = 5'd17;
	localparam logic [4:0] S_C_C    = 5'd18;
	localparam logic [4:0] S_DONE   = 5'd19;

	logic [4:0]  state_q;
	logic [8:0]  num_vars_q;
	logic [12:0] ec_q;
	logic [1:0]  err_q;
	logic [9:0]  a_q, b_q, na_q, nb_q;
	logic        last_q;
	logic [1:0]  k_q;
	logic [9:0]  root_q, vc_q, cc_q, sp_q, fp_q, u_q, v_q, w_q, p_q, chk_q, compa_q;
	logic [12:0] e_q, pe_q;
	node_word_t  uw_q;
	logic        sat_q;
	logic [8:0]  clr_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [8:0]  n_act;
	logic [9:0]  top_node;
	logic [9:0]  from_cur, to_cur;
	logic        lits_ok;

	logic        n_we;
	logic [8:0]  n_waddr, n_raddr;
	node_word_t  n_wdata, n_rd;
	logic        e_we;
	logic [11:0] e_waddr, e_raddr;
	edge_word_t  e_wdata, e_rd;
	logic        p_we;
	logic [8:0]  p_waddr, p_raddr;
	logic [9:0]  p_wdata, p_rd;
	logic        f_we;
	logic [8:0]  f_waddr, f_raddr;
	frame_t      f_wdata, f_rd;

	logic [9:0]  sp_dec, fp_dec, vc_inc, kn_node;
	node_word_t  new_w;

	assign n_act    = (num_vars_q == 9'd0) ? 9'd1 :
	                  ((num_vars_q > 9'(MAX_VARS)) ? 9'(MAX_VARS) : num_vars_q);
	assign top_node = {n_act, 1'b0};
	assign lits_ok  = (req.lit_a != 10'd0) && (req.lit_a <= top_node) &&
	                  (req.lit_b != 10'd0) && (req.lit_b <= top_node);
	assign sp_dec   = sp_q - 10'd1;
	assign fp_dec   = fp_q - 10'd1;
	assign vc_inc   = vc_q + 10'd1;
	assign kn_node  = chk_q + {1'b0, n_act};

	always_comb begin
		case (k_q)
			2'd0: begin from_cur = a_q;  to_cur = nb_q; end
			2'd1: begin from_cur = nb_q; to_cur = a_q;  end
			2'd2: begin from_cur = na_q; to_cur = b_q;  end
			default: begin from_cur = b_q; to_cur = na_q; end
		endcase
	end

	// Word for a freshly discovered node: its list head with visit and low set.
	always_comb begin
		new_w       = n_rd;
		new_w.visit = vc_inc;
		new_w.low   = vc_inc;
		new_w.comp  = 10'd0;
	end

	always_comb begin
		n_we    = 1'b0;
		n_waddr = '0;
		n_wdata = '0;
		n_raddr = '0;
		e_we    = 1'b0;
		e_waddr = ec_q[11:0];
		e_wdata = '0;
		e_raddr = '0;
		p_we    = 1'b0;
		p_waddr = sp_q[8:0];
		p_wdata = '0;
		p_raddr = sp_dec[8:0];
		f_we    = 1'b0;
		f_waddr = fp_q[8:0];
		f_wdata = '0;
		f_raddr = fp_dec[8:0];
		unique case (state_q)
			S_CLR: begin
				n_we    = 1'b1;
				n_waddr = clr_q;
			end
			S_ADD_RD: n_raddr = node_addr(from_cur);
			S_ADD_WR: begin
				e_we         = 1'b1;
				e_wdata      = '{target: to_cur, link: n_rd.head};
				n_we         = 1'b1;
				n_waddr      = node_addr(from_cur);
				n_wdata      = n_rd;
				n_wdata.head = ec_q + 13'd1;
			end
			S_R_RD: n_raddr = node_addr(root_q);
			S_R_CHK: begin
				if (n_rd.visit == 10'd0) begin
					n_we    = 1'b1;
					n_waddr = node_addr(root_q);
					n_wdata = new_w;
					p_we    = 1'b1;
					p_wdata = root_q;
				end
			end
			S_W_TOP: e_raddr = edge_addr(e_q);
			S_W_EDGE: n_raddr = node_addr(e_rd.target);
			S_W_V: begin
				if (n_rd.comp == 10'd0) begin
					if (n_rd.visit == 10'd0) begin
						n_we    = 1'b1;
						n_waddr = node_addr(v_q);
						n_wdata = new_w;
						p_we    = 1'b1;
						p_wdata = v_q;
						f_we    = 1'b1;
						f_wdata = '{node: u_q, eptr: e_q};
					end else if (n_rd.visit < uw_q.low) begin
						n_we        = 1'b1;
						n_waddr     = node_addr(u_q);
						n_wdata     = uw_q;
						n_wdata.low = n_rd.visit;
					end
				end
			end
			S_P_B: n_raddr = node_addr(p_rd);
			S_P_C: begin
				n_we         = 1'b1;
				n_waddr      = node_addr(w_q);
				n_wdata      = n_rd;
				n_wdata.comp = cc_q;
			end
			S_F_B: n_raddr = node_addr(f_rd.node);
			S_F_C: begin
				if (uw_q.low < n_rd.low) begin
					n_we        = 1'b1;
					n_waddr     = node_addr(p_q);
					n_wdata     = n_rd;
					n_wdata.low = uw_q.low;
				end
			end
			S_C_A: n_raddr = node_addr(chk_q);
			S_C_B: n_raddr = node_addr(kn_node);
			default: ;
		endcase
	end

	tsat_ram #(.DW($bits(node_word_t)), .AW(9)) u_node_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rd)
	);
	tsat_ram #(.DW($bits(edge_word_t)), .AW(12)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rd)
	);
	tsat_ram #(.DW(10), .AW(9)) u_pend_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);
	tsat_ram #(.DW($bits(frame_t)), .AW(9)) u_frame_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rd)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			a_q    <= req.lit_a;
			b_q    <= req.lit_b;
			na_q   <= negate(req.lit_a, n_act);
			nb_q   <= negate(req.lit_b, n_act);
			last_q <= req.last;
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.satisfiable <= sat_q;
			rsp_q.status      <= err_q[1] ? ST_RANGE : (err_q[0] ? ST_DROPPED : ST_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			num_vars_q  <= 9'(MAX_VARS);
			ec_q        <= '0;
			err_q       <= '0;
			k_q         <= '0;
			root_q      <= '0;
			vc_q        <= '0;
			cc_q        <= '0;
			sp_q        <= '0;
			fp_q        <= '0;
			u_q         <= '0;
			v_q         <= '0;
			w_q         <= '0;
			p_q         <= '0;
			e_q         <= '0;
			pe_q        <= '0;
			uw_q        <= '0;
			chk_q       <= '0;
			compa_q     <= '0;
			sat_q       <= 1'b0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_vars_q <= cfg_wdata;
			end
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 9'd1;
					if (clr_q == 9'd511) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						k_q <= 2'd0;
						if (!lits_ok) begin
							err_q[1] <= 1'b1;
							state_q  <= req.last ? S_INIT : S_IDLE;
						end else if (ec_q > 13'(MAX_EDGES - 4)) begin
							err_q[0] <= 1'b1;
							state_q  <= req.last ? S_INIT : S_IDLE;
						end else begin
							state_q <= S_ADD_RD;
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					ec_q <= ec_q + 13'd1;
					k_q  <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= last_q ? S_INIT : S_IDLE;
					end else begin
						state_q <= S_ADD_RD;
					end
				end
				S_INIT: begin
					root_q  <= 10'd1;
					vc_q    <= '0;
					cc_q    <= '0;
					sp_q    <= '0;
					fp_q    <= '0;
					state_q <= S_R_RD;
				end
				S_R_RD: begin
					if (root_q > top_node) begin
						chk_q   <= 10'd1;
						state_q <= S_C_A;
					end else begin
						state_q <= S_R_CHK;
					end
				end
				S_R_CHK: begin
					if (n_rd.visit != 10'd0) begin
						root_q  <= root_q + 10'd1;
						state_q <= S_R_RD;
					end else begin
						vc_q    <= vc_inc;
						sp_q    <= sp_q + 10'd1;
						u_q     <= root_q;
						e_q     <= n_rd.head;
						uw_q    <= new_w;
						state_q <= S_W_TOP;
					end
				end
				S_W_TOP: begin
					if (e_q != 13'd0) begin
						state_q <= S_W_EDGE;
					end else if (uw_q.low == uw_q.visit) begin
						cc_q    <= cc_q + 10'd1;
						state_q <= S_P_A;
					end else begin
						state_q <= S_F_A;
					end
				end
				S_W_EDGE: begin
					e_q <= e_rd.link;
					v_q <= e_rd.target;
					if (e_rd.target == 10'd0 || e_rd.target > top_node) begin
						state_q <= S_W_TOP;
					end else begin
						state_q <= S_W_V;
					end
				end
				S_W_V: begin
					state_q <= S_W_TOP;
					if (n_rd.comp == 10'd0) begin
						if (n_rd.visit == 10'd0) begin
							vc_q <= vc_inc;
							sp_q <= sp_q + 10'd1;
							fp_q <= fp_q + 10'd1;
							u_q  <= v_q;
							e_q  <= n_rd.head;
							uw_q <= new_w;
						end else if (n_rd.visit < uw_q.low) begin
							uw_q.low <= n_rd.visit;
						end
					end
				end
				S_P_A: begin
					sp_q    <= sp_dec;
					state_q <= S_P_B;
				end
				S_P_B: begin
					w_q     <= p_rd;
					state_q <= S_P_C;
				end
				S_P_C: state_q <= (w_q == u_q) ? S_F_A : S_P_A;
				S_F_A: begin
					if (fp_q == 10'd0) begin
						root_q  <= root_q + 10'd1;
						state_q <= S_R_RD;
					end else begin
						fp_q    <= fp_dec;
						state_q <= S_F_B;
					end
				end
				S_F_B: begin
					p_q     <= f_rd.node;
					pe_q    <= f_rd.eptr;
					state_q <= S_F_C;
				end
				S_F_C: begin
					u_q <= p_q;
					e_q <= pe_q;
					// The parent takes the child's low link when it is smaller.
					uw_q    <= (uw_q.low < n_rd.low) ? n_wdata : n_rd;
					state_q <= S_W_TOP;
				end
				S_C_A: state_q <= S_C_B;
				S_C_B: begin
					compa_q <= n_rd.comp;
					state_q <= S_C_C;
				end
				S_C_C: begin
					if (n_rd.comp == compa_q) begin
						sat_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (chk_q == {1'b0, n_act}) begin
						sat_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						chk_q   <= chk_q + 10'd1;
						state_q <= S_C_A;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						ec_q    <= '0;
						err_q   <= '0;
						clr_q   <= '0;
						state_q <= S_CLR;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// Every open call frame has its node on the pending stack.
	`TSAT_ASSERT(a_frames_le_pending, fp_q <= sp_q, "call frames exceed pending nodes")
	`TSAT_ASSERT(a_edge_count_bound, ec_q <= 13'(MAX_EDGES), "edge count beyond store")
	`TSAT_ASSERT_IMP(a_idle_whole_groups, state_q == S_IDLE, ec_q[1:0] == 2'd0, "partial edge group")
endmodule

### rtl/tsat_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tsat_ram #(
	parameter int DW = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sim/tb_two_sat_scc_checker_unit.sv
// Self-checking testbench for the two-SAT component checker.
// Drives constraint words and checks each set's verdict against a model or a table.
// Depends on tsat_pkg and two_sat_scc_checker_unit.
`timescale 1ns / 1ps
module tb_two_sat_scc_checker_unit;
	import tsat_pkg::*;

	localparam int NODE_SLOTS   = 2 * MAX_VARS + 1;
	localparam int WATCHDOG_MAX = 200000;
	localparam int SETTLE       = 700;
	localparam int TARGET_WORDS = 1800;
	localparam int NO_CFG       = -1;
	localparam logic [1:0] FLAG_FULL  = 2'b01;
	localparam logic [1:0] FLAG_RANGE = 2'b10;

	typedef struct {
		int         cfg;
		logic [9:0] a;
		logic [9:0] b;
		logic       last;
		bit         glance;
		logic       sat;
		logic [1:0] st;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [8:0] cfg_wdata;

	two_sat_scc_checker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the constraint graph and the verdict search.
	int         var_count;
	logic [9:0] arc_dest [0:MAX_EDGES-1];
	logic [12:0] arc_next [0:MAX_EDGES-1];
	logic [12:0] list_head [0:NODE_SLOTS-1];
	int         arc_total;
	logic [1:0] set_flags;
	int         order_of [0:NODE_SLOTS-1];
	int         low_of [0:NODE_SLOTS-1];
	int         group_of [0:NODE_SLOTS-1];
	int         open_nodes [0:NODE_SLOTS-1];
	int         walk_node [0:NODE_SLOTS-1];
	int         walk_arc [0:NODE_SLOTS-1];

	rsp_t verdict_q[$];
	bit   glance_on;
	rsp_t glance_val;
	int   words_taken;
	int   mismatches;
	int   idle_cycles;
	bit   hold_req;
	bit   quiet;
	int   words_sent;

	dir_row_t dir_tab [0:17] = '{
		'{NO_CFG, 10'd1, 10'd1, 1'b1, 1, 1'b0, ST_OK},
		'{NO_CFG, 10'd0, 10'd5, 1'b1, 1, 1'b1, ST_RANGE},
		'{NO_CFG, 10'd1023, 10'd512, 1'b1, 1, 1'b1, ST_RANGE},
		'{NO_CFG, 10'd512, 10'd1, 1'b1, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd1, 10'd2, 1'b0, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd2, 10'd3, 1'b0, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd3, 10'd1, 1'b1, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd1, 10'd1, 1'b0, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd0, 10'd0, 1'b1, 1, 1'b0, ST_RANGE},
		'{NO_CFG, 10'd256, 10'd257, 1'b1, 0, 1'b0, ST_OK},
		'{1, 10'd1, 10'd2, 1'b1, 1, 1'b1, ST_OK},
		'{NO_CFG, 10'd2, 10'd2, 1'b1, 1, 1'b0, ST_OK},
		'{NO_CFG, 10'd3, 10'd1, 1'b1, 1, 1'b1, ST_RANGE},
		'{0, 10'd2, 10'd1, 1'b1, 1, 1'b1, ST_OK},
		'{511, 10'd512, 10'd512, 1'b1, 1, 1'b0, ST_OK},
		'{256, 10'd1, 10'd257, 1'b0, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd2, 10'd258, 1'b0, 0, 1'b0, ST_OK},
		'{NO_CFG, 10'd1, 10'd2, 1'b1, 0, 1'b0, ST_OK}
	};

	function automatic int vars_in_use();
		if (var_count < 1) return 1;
		if (var_count > MAX_VARS) return MAX_VARS;
		return var_count;
	endfunction

	function automatic void link_arc(input int from, input int to);
		arc_dest[arc_total] = to[9:0];
		arc_next[arc_total] = list_head[from];
		list_head[from] = 13'(arc_total + 1);
		arc_total++;
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NODE_SLOTS; i++) list_head[i] = '0;
		arc_total = 0;
		set_flags = '0;
	endfunction

	// Iterative Tarjan search; true when no variable meets its negation.
	function automatic bit graph_satisfiable();
		int n, top, sp, fp, u, v, e, w, p, stamp, groups;
		n = vars_in_use();
		top = 2 * n;
		sp = 0;
		fp = 0;
		stamp = 0;
		groups = 0;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			order_of[i] = 0;
			group_of[i] = 0;
		end
		for (int root = 1; root <= top; root++) begin
			if (order_of[root] != 0) continue;
			stamp++;
			order_of[root] = stamp;
			low_of[root] = stamp;
			open_nodes[sp++] = root;
			walk_node[fp] = root;
			walk_arc[fp] = list_head[root];
			fp++;
			while (fp > 0) begin
				e = walk_arc[fp-1];
				u = walk_node[fp-1];
				if (e != 0) begin
					v = arc_dest[e-1];
					walk_arc[fp-1] = arc_next[e-1];
					if (v == 0 || v > top || group_of[v] != 0) continue;
					if (order_of[v] == 0) begin
						stamp++;
						order_of[v] = stamp;
						low_of[v] = stamp;
						open_nodes[sp++] = v;
						walk_node[fp] = v;
						walk_arc[fp] = list_head[v];
						fp++;
					end else if (order_of[v] < low_of[u]) begin
						low_of[u] = order_of[v];
					end
					continue;
				end
				if (low_of[u] == order_of[u]) begin
					groups++;
					while (sp > 0) begin
						sp--;
						w = open_nodes[sp];
						group_of[w] = groups;
						if (w == u) break;
					end
				end
				fp--;
				if (fp > 0) begin
					p = walk_node[fp-1];
					if (low_of[u] < low_of[p]) low_of[p] = low_of[u];
				end
			end
		end
		for (u = 1; u <= n; u++)
			if (group_of[u] == group_of[u+n]) return 0;
		return 1;
	endfunction

	function automatic int flip_lit(input int lit, input int n);
		return (lit > n) ? lit - n : lit + n;
	endfunction

	function automatic bit absorb_word(input req_t w, output rsp_t verdict);
		int n, a, b;
		n = vars_in_use();
		a = w.lit_a;
		b = w.lit_b;
		if (a == 0 || a > 2 * n || b == 0 || b > 2 * n) begin
			set_flags |= FLAG_RANGE;
		end else if (arc_total + 4 > MAX_EDGES) begin
			set_flags |= FLAG_FULL;
		end else begin
			link_arc(a, flip_lit(b, n));
			link_arc(flip_lit(b, n), a);
			link_arc(flip_lit(a, n), b);
			link_arc(b, flip_lit(a, n));
		end
		verdict = '0;
		if (!w.last) return 0;
		verdict.satisfiable = graph_satisfiable();
		verdict.status = set_flags[1] ? ST_RANGE : (set_flags[0] ? ST_DROPPED : ST_OK);
		clear_graph();
		return 1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sampling at the rising edge: prediction, checking and the watchdog.
	always @(posedge clk) begin
		rsp_t pred;
		rsp_t want;
		bit busy;
		busy = 0;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				busy = 1;
				if (absorb_word(req, pred)) begin
					if (glance_on) begin
						pred = glance_val;
						glance_on = 0;
					end
					verdict_q = {verdict_q, pred};
				end
				words_taken++;
			end
			// A register write lands after any word taken at the same edge.
			if (cfg_we) var_count = cfg_wdata;
			if (rsp_valid && rsp_ready) begin
				busy = 1;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word sat=%0b status=%0d",
							rsp.satisfiable, rsp.status);
				end else begin
					want = verdict_q.pop_front();
					if (want.satisfiable !== rsp.satisfiable || want.status !== rsp.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected sat=%0b st=%0d, got sat=%0b st=%0d",
								want.satisfiable, want.status, rsp.satisfiable, rsp.status);
					end
				end
			end
			idle_cycles = busy ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("Timeout: no word moved for %0d cycles", WATCHDOG_MAX);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, a quiet stretch and one long hold-off.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 0;
			end else begin
				rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
			end
		end
	end

	// Called at a falling edge; leaves valid high after acceptance.
	task automatic send_word(input logic [9:0] a, input logic [9:0] b, input logic last);
		int start;
		req_t w;
		w.lit_a = a;
		w.lit_b = b;
		w.last = last;
		if (!quiet && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		start = words_taken;
		do @(negedge clk); while (words_taken == start);
		words_sent++;
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_vars(input int value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value[8:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [9:0] pick_lit(input int n);
		if ($urandom_range(99) < 8) return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(1, 2 * n));
	endfunction

	initial begin
		int n, len, set_no;
		int sizes [0:9];
		sizes = '{1, 2, 3, 4, 5, 8, 16, 0, 511, 6};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		var_count = MAX_VARS;
		clear_graph();
		glance_on = 0;
		words_taken = 0;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 0;
		quiet = 0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg != NO_CFG) write_vars(dir_tab[i].cfg);
			if (dir_tab[i].glance) begin
				glance_val.satisfiable = dir_tab[i].sat;
				glance_val.status = dir_tab[i].st;
				glance_on = 1;
			end
			send_word(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last);
		end

		set_no = 0;
		while (words_sent < TARGET_WORDS) begin
			if (set_no % 8 == 0) begin
				n = (set_no % 40 == 16) ? MAX_VARS : sizes[$urandom_range(0, 9)];
				if (set_no == 24) n = 4;
				write_vars(n);
			end
			if (n < 1) n = 1;
			if (n > MAX_VARS) n = MAX_VARS;
			quiet = (words_sent >= 1500 && words_sent < 1700);
			if (set_no == 6) hold_req = 1;
			if (set_no == 12) drain_results();
			len = $urandom_range(1, 10);
			// One oversized set overflows the edge store and also carries a bad literal.
			if (set_no == 24) len = MAX_CONSTRAINTS + 6;
			for (int k = 0; k < len; k++) begin
				if (set_no == 24 && k == 500)
					send_word(10'd0, pick_lit(n), 1'b0);
				else if (set_no == 24)
					send_word(10'($urandom_range(1, 2 * n)), 10'($urandom_range(1, 2 * n)),
						k == len - 1);
				else
					send_word(pick_lit(n), pick_lit(n), k == len - 1);
			end
			set_no++;
		end

		drain_results();
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
